[design/wildcard_byte_pattern_scan_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the wildcard byte pattern scan
// Clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SCAN_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define WBPS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define WBPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/wbps_pkg.sv]
// ----------------------------------------------------------------------------
// wbps_pkg
// Types and constants shared by the wildcard byte pattern scan modules.
// ----------------------------------------------------------------------------
package wbps_pkg;

	localparam int MAX_PATTERN_BYTES = 16;
	localparam int OFFSET_BITS       = 32;
	localparam int REG_PATTERN_BYTES = 16;
	localparam int LEN_CAP   = (MAX_PATTERN_BYTES < REG_PATTERN_BYTES) ?
	                           MAX_PATTERN_BYTES : REG_PATTERN_BYTES;
	localparam int LEN_W     = $clog2(LEN_CAP + 1);
	localparam int WIN_IDX_W = (LEN_CAP > 1) ? $clog2(LEN_CAP) : 1;

	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int LEN_REG_W  = 5;
	localparam int OFS_OUT_W  = 32;

	localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LOW   = 2'd0,
		REG_PAT_HIGH  = 2'd1,
		REG_WILD_MASK = 2'd2,
		REG_PAT_LEN   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       region_end;
	} in_t;

	typedef struct packed {
		logic                 found;
		logic [OFS_OUT_W-1:0] match_offset;
	} out_t;

	typedef struct packed {
		logic [8*REG_PATTERN_BYTES-1:0] pattern;
		logic [REG_PATTERN_BYTES-1:0]   wild;
		logic [LEN_W-1:0]               eff_len;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic res_valid;
	} s1_status_t;

endpackage

[design/wildcard_byte_pattern_scan.sv]
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan
// Finds the first offset in a byte stream where a wildcard signature matches.
// ----------------------------------------------------------------------------
// Path: an accepted byte enters the window (input) register, the combinational
// window compare sits between it and the output register that drives out_item.
// Throughput: one byte per cycle while a full output register is not stalled.
// Reset: arst_n clears position, match flag, valid flags and configuration
// (length reads as 1); the byte window is not reset.
module wildcard_byte_pattern_scan (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  wbps_pkg::in_t                  in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output wbps_pkg::out_t                 out_item
);
	import wbps_pkg::*;

	cfg_t       cfg;
	s1_status_t status;
	out_t       res;
	logic       advance;
	logic       in_accept;
	logic       out_valid_q;
	out_t       out_q;

	wbps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	wbps_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_accept (in_accept),
		.item      (in_item),
		.advance   (advance),
		.status    (status),
		.res       (res)
	);

	// stage 1 moves whenever the output register is empty or draining
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = status.busy && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= status.res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && status.res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

[design/wbps_cfg.sv]
// ----------------------------------------------------------------------------
// wbps_cfg
// Configuration registers and the clamped signature length.
// ----------------------------------------------------------------------------
module wbps_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output wbps_pkg::cfg_t                 cfg
);
	import wbps_pkg::*;

	logic [63:0]                  pat_low_q;
	logic [63:0]                  pat_high_q;
	logic [REG_PATTERN_BYTES-1:0] wild_q;
	logic [LEN_REG_W-1:0]         len_q;
	logic [LEN_W-1:0]             eff_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			wild_q     <= '0;
			len_q      <= LEN_REG_W'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PAT_LOW:   pat_low_q  <= cfg_wdata[63:0];
				REG_PAT_HIGH:  pat_high_q <= cfg_wdata[63:0];
				REG_WILD_MASK: wild_q     <= cfg_wdata[REG_PATTERN_BYTES-1:0];
				REG_PAT_LEN:   len_q      <= cfg_wdata[LEN_REG_W-1:0];
			endcase
		end
	end

	// zero means one, anything past the window depth saturates
	always_comb begin
		if (len_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (len_q > LEN_REG_W'(LEN_CAP)) begin
			eff_len = LEN_W'(LEN_CAP);
		end else begin
			eff_len = LEN_W'(len_q);
		end
	end

	assign cfg.pattern = {pat_high_q, pat_low_q};
	assign cfg.wild    = wild_q;
	assign cfg.eff_len = eff_len;

endmodule

[design/wbps_match.sv]
// ----------------------------------------------------------------------------
// wbps_match
// Byte window, position counter and parallel signature compare stage.
// ----------------------------------------------------------------------------
`include "wildcard_byte_pattern_scan_defines.svh"

module wbps_match (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wbps_pkg::cfg_t       cfg,
	input  logic                 in_accept,
	input  wbps_pkg::in_t        item,
	input  logic                 advance,
	output wbps_pkg::s1_status_t status,
	output wbps_pkg::out_t       res
);
	import wbps_pkg::*;

	logic [7:0]             window_q [LEN_CAP];
	logic [OFFSET_BITS-1:0] count_q;
	logic [OFFSET_BITS-1:0] count_next;
	logic [OFFSET_BITS-1:0] count_s1;
	logic                   valid_s1;
	logic                   last_s1;
	logic                   reported_q;

	logic [WIN_IDX_W-1:0]   sel_idx [LEN_CAP];
	logic                   hit;
	logic [OFFSET_BITS-1:0] len_ext;
	logic [OFFSET_BITS-1:0] diff;
	logic [63:0]            ofs_ext;
	logic                   count_ok;
	logic                   do_found;
	logic                   do_miss;

	assign count_next = (count_q == POS_MAX) ? count_q : count_q + OFFSET_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_accept) begin
				count_q  <= item.region_end ? '0 : count_next;
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// window holds the view of the item in stage 1; it only moves on accept
	always_ff @(posedge clk) begin
		if (in_accept) begin
			window_q[0] <= item.data_byte;
			for (int i = 1; i < LEN_CAP; i++) begin
				window_q[i] <= window_q[i-1];
			end
			count_s1 <= count_next;
			last_s1  <= item.region_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reported_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			if (last_s1) begin
				reported_q <= 1'b0;
			end else if (do_found) begin
				reported_q <= 1'b1;
			end
		end
	end

	// signature byte j lines up with window entry len-1-j
	always_comb begin
		for (int j = 0; j < LEN_CAP; j++) begin
			sel_idx[j] = WIN_IDX_W'(cfg.eff_len - LEN_W'(1) - LEN_W'(j));
		end
	end

	always_comb begin
		hit = 1'b1;
		for (int j = 0; j < LEN_CAP; j++) begin
			if (LEN_W'(j) < cfg.eff_len && !cfg.wild[j] &&
			    window_q[sel_idx[j]] != cfg.pattern[8*j +: 8]) begin
				hit = 1'b0;
			end
		end
	end

	assign len_ext  = OFFSET_BITS'(cfg.eff_len);
	assign count_ok = count_s1 >= len_ext;
	assign diff     = count_s1 - len_ext;
	assign ofs_ext  = 64'(diff);
	assign do_found = !reported_q && count_ok && hit;
	assign do_miss  = last_s1 && !reported_q;

	assign res.found        = do_found;
	assign res.match_offset = do_found ? ofs_ext[OFS_OUT_W-1:0] : '0;

	assign status.busy      = valid_s1;
	assign status.res_valid = valid_s1 && (do_found || do_miss);

	`WBPS_ASSERT_SAME(a_miss_offset_zero, status.res_valid && !res.found,
		res.match_offset == '0, "not-found item carries a nonzero offset")
	`WBPS_ASSERT_NEXT(a_last_clears_count, in_accept && item.region_end,
		count_q == '0, "position not cleared after last byte")
	`WBPS_ASSERT_NEXT(a_found_sets_flag, valid_s1 && advance && do_found && !last_s1,
		reported_q, "match not remembered for the rest of the region")

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams byte regions into the wildcard signature scanner and checks every
// found / not-found report against a scoreboard predictor. Directed regions
// come first, then random regions with the signature planted, spoiled or
// absent, under several register settings and random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;

	import wbps_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_CYCLES = 8;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_t                   in_item = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_t                  out_item;

	wildcard_byte_pattern_scan dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	always #5 clk = ~clk;

	// register shadow
	logic [63:0] pat_lo = '0;
	logic [63:0] pat_hi = '0;
	logic [15:0] wild_mask = '0;
	logic [4:0]  len_reg = 5'd1;

	// scanner state shadow
	logic [7:0]             recent [MAX_PATTERN_BYTES];
	logic [OFFSET_BITS-1:0] bytes_seen = '0;
	logic                   reported = 1'b0;

	in_t  byte_queue [$];
	out_t expected_reports [$];

	int  mismatch_count = 0;
	int  cycle_count = 0;
	int  send_gap = 0;
	int  stall_left = 0;
	bit  send_idle = 1'b0;
	bit  recv_idle = 1'b0;

	function automatic int scan_len();
		int n;
		n = len_reg;
		if (n < 1)
			n = 1;
		if (n > LEN_CAP)
			n = LEN_CAP;
		return n;
	endfunction

	function automatic logic [7:0] sig_byte(int j);
		logic [127:0] p;
		p = {pat_hi, pat_lo};
		return p[8*j +: 8];
	endfunction

	function automatic bit window_hit(int len);
		for (int j = 0; j < len; j++) begin
			if (!wild_mask[j] && recent[len-1-j] != sig_byte(j))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic scan_next_byte(in_t it);
		out_t r;
		int   len;
		len = scan_len();
		for (int i = MAX_PATTERN_BYTES - 1; i > 0; i--)
			recent[i] = recent[i-1];
		recent[0] = it.data_byte;
		if (bytes_seen != POS_MAX)
			bytes_seen = bytes_seen + 1'b1;
		if (!reported && bytes_seen >= OFFSET_BITS'(len) && window_hit(len)) begin
			reported = 1'b1;
			r.found = 1'b1;
			r.match_offset = OFS_OUT_W'(bytes_seen - OFFSET_BITS'(len));
			expected_reports.insert(expected_reports.size(), r);
		end else if (it.region_end && !reported) begin
			r.found = 1'b0;
			r.match_offset = '0;
			expected_reports.insert(expected_reports.size(), r);
		end
		if (it.region_end) begin
			bytes_seen = '0;
			reported = 1'b0;
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 1))
			return sig_byte($urandom_range(0, 15));
		return 8'($urandom);
	endfunction

	// sender: one item held until accepted, then an optional gap
	always @(posedge clk) begin : driver
		logic nv;
		nv = in_valid;
		if (in_valid && !in_stall) begin
			scan_next_byte(in_item);
			nv = 1'b0;
		end
		if (!nv && arst_n) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (byte_queue.size() != 0) begin
				in_item <= byte_queue.pop_front();
				nv = 1'b1;
				send_gap = send_idle ? pick_gap() : 0;
			end
		end
		in_valid <= nv;
	end

	always @(posedge clk) begin : monitor
		out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_reports.size() == 0) begin
				$display("%0t: unexpected report found=%0b offset=%0d", $time,
					out_item.found, out_item.match_offset);
				mismatch_count++;
			end else begin
				want = expected_reports.pop_front();
				if (out_item.found !== want.found) begin
					$display("%0t: found expected %0b actual %0b", $time,
						want.found, out_item.found);
					mismatch_count++;
				end
				if (out_item.match_offset !== want.match_offset) begin
					$display("%0t: match_offset expected %0d actual %0d", $time,
						want.match_offset, out_item.match_offset);
					mismatch_count++;
				end
			end
		end
		if (stall_left == 0 && recv_idle && $urandom_range(0, 3) == 0)
			stall_left = pick_gap();
		out_stall <= (stall_left != 0);
		if (stall_left != 0)
			stall_left--;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d reports outstanding", $time,
				expected_reports.size());
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_PAT_LOW: begin
				pat_lo = val;
			end
			REG_PAT_HIGH: begin
				pat_hi = val;
			end
			REG_WILD_MASK: begin
				wild_mask = val[15:0];
			end
			REG_PAT_LEN: begin
				len_reg = val[4:0];
			end
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// upper bits of the narrow registers get random junk
	task automatic configure(logic [63:0] lo, logic [63:0] hi, logic [15:0] mask,
			logic [4:0] len);
		logic [63:0] v;
		write_reg(REG_PAT_LOW, lo);
		write_reg(REG_PAT_HIGH, hi);
		v = rand64();
		v[15:0] = mask;
		write_reg(REG_WILD_MASK, v);
		v = rand64();
		v[4:0] = len;
		write_reg(REG_PAT_LEN, v);
	endtask

	task automatic drain();
		while (byte_queue.size() != 0 || in_valid || expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// plant_at < 0: no signature planted; close = 0 leaves the region open
	task automatic add_region(int n, int plant_at, bit spoil, bit close);
		logic [7:0] region_bytes [$];
		in_t        it;
		int         len;
		int         j;
		len = scan_len();
		for (int i = 0; i < n; i++)
			region_bytes.insert(region_bytes.size(), pick_byte());
		if (plant_at >= 0 && plant_at + len <= n) begin
			for (int k = 0; k < len; k++) begin
				if (!wild_mask[k])
					region_bytes[plant_at+k] = sig_byte(k);
			end
			if (spoil) begin
				for (int t = 0; t < 16; t++) begin
					j = $urandom_range(0, len - 1);
					if (!wild_mask[j]) begin
						region_bytes[plant_at+j][$urandom_range(0, 7)] ^= 1'b1;
						break;
					end
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			it.data_byte = region_bytes[i];
			it.region_end = close && (i == n - 1);
			byte_queue.insert(byte_queue.size(), it);
		end
	endtask

	task automatic random_regions(int n_items);
		int made;
		int n;
		int len;
		int at;
		int r;
		made = 0;
		len = scan_len();
		while (made < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 80)
				n = $urandom_range(1, 2 * len + 6);
			else if (r < 96)
				n = $urandom_range(1, 60);
			else
				n = $urandom_range(100, 250);
			at = -1;
			r = $urandom_range(0, 99);
			if (n >= len) begin
				if (r < 55)
					at = $urandom_range(0, n - len);
				else if (r < 70)
					at = n - len;
			end
			add_region(n, at, $urandom_range(0, 4) == 0, 1'b1);
			made += n;
		end
		// sometimes the region runs on into the next register setting
		if ($urandom_range(0, 2) == 0)
			add_region($urandom_range(1, 20), -1, 1'b0, 1'b0);
	endtask

	initial begin : sequencer
		logic [8:0] directed_items [20];
		in_t        it;
		directed_items = '{
			// region shorter than the signature
			9'h000, 9'h1FF,
			// single-byte region
			9'h100,
			// match on the last byte, wildcard over 0x77
			9'h011, 9'h000, 9'h0FF, 9'h077, 9'h15A,
			// match mid-region, later match and region end stay silent
			9'h000, 9'h0FF, 9'h000, 9'h05A, 9'h000, 9'h0FF, 9'h033, 9'h15A,
			// near miss
			9'h000, 9'h0FF, 9'h012, 9'h15B
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		configure({$urandom, 32'h5A99FF00}, rand64(), 16'h0004, 5'd4);
		foreach (directed_items[i]) begin
			it.data_byte = directed_items[i][7:0];
			it.region_end = directed_items[i][8];
			byte_queue.insert(byte_queue.size(), it);
		end
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			case (ph)
				0: begin
					configure(rand64(), rand64(), 16'h0000, 5'd0);
				end
				1: begin
					configure('1, '1, 16'h0000, 5'd16);
				end
				2: begin
					configure(rand64(), rand64(), 16'hFFFF, 5'd17);
				end
				3: begin
					configure(rand64(), rand64(), 16'($urandom), 5'd31);
				end
				4: begin
					configure(rand64(), rand64(), 16'hFFFF, 5'd1);
				end
				5: begin
					configure('0, '0, 16'h0000, 5'd2);
				end
				default: begin
					configure(rand64(), rand64(), 16'($urandom & $urandom),
						5'($urandom_range(0, 31)));
				end
			endcase
			// first random phase runs flat out on both sides
			send_idle = (ph != 0) && ($urandom_range(0, 3) != 0);
			recv_idle = (ph != 0) && ($urandom_range(0, 3) != 0);
			random_regions(110);
			drain();
		end

		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[wildcard_byte_pattern_scan.f]
+incdir+design
design/wbps_pkg.sv
design/wbps_cfg.sv
design/wbps_match.sv
design/wildcard_byte_pattern_scan.sv
tb/testbench.sv
